@@ hw/rtl/sts_pkg.sv @@
//------------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the syntax token styler.
//------------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

   // Fixed field widths of the channels.
   localparam int CHAR_W     = 8;
   localparam int KW_INDEX_W = 5;
   localparam int KW_CHARS_W = 64;
   localparam int KW_LEN_W   = 4;
   localparam int COUNT_W    = 6;
   localparam int STYLE_W    = 3;

   // Input commands.
   localparam logic CMD_TEXT = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Run styles.
   localparam logic [STYLE_W-1:0] ST_DEFAULT = 3'd0;
   localparam logic [STYLE_W-1:0] ST_STRING  = 3'd1;
   localparam logic [STYLE_W-1:0] ST_NUMBER  = 3'd2;
   localparam logic [STYLE_W-1:0] ST_IDENT   = 3'd3;
   localparam logic [STYLE_W-1:0] ST_KEYWORD = 3'd4;
   localparam logic [STYLE_W-1:0] ST_LABEL   = 3'd5;

   // Characters with a meaning of their own.
   localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h22;
   localparam logic [CHAR_W-1:0] CH_DOLLAR     = 8'h24;
   localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_X          = 8'h78;

   // Character class flags worked out by the front end.
   typedef struct packed {
      logic quote;
      logic digit;
      logic alpha;
      logic hex_or_x;
      logic colon;
      logic under_dollar;
   } sts_class_type;

   // One decoded item as it travels from the front end to the back end.
   typedef struct packed {
      logic                  load;
      logic                  line_start;
      logic [CHAR_W-1:0]     char_code;
      sts_class_type         cls;
      logic [KW_INDEX_W-1:0] kw_index;
      logic [KW_CHARS_W-1:0] kw_chars;
      logic [KW_LEN_W-1:0]   kw_length;
   } sts_op_type;

endpackage

`default_nettype wire

@@ hw/rtl/sts_req_if.sv @@
//------------------------------------------------------------------------------
// sts_req_if
// Input channel: text characters and keyword table loads.
//------------------------------------------------------------------------------
`default_nettype none

interface sts_req_if import sts_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [CHAR_W-1:0]     char_code;
   logic                  line_start;
   logic [KW_INDEX_W-1:0] kw_index;
   logic [KW_CHARS_W-1:0] kw_chars;
   logic [KW_LEN_W-1:0]   kw_length;

   modport source (
      output valid, command, char_code, line_start, kw_index, kw_chars, kw_length,
      input  ready
   );

   modport sink (
      input  valid, command, char_code, line_start, kw_index, kw_chars, kw_length,
      output ready
   );

endinterface

`default_nettype wire

@@ hw/rtl/sts_rsp_if.sv @@
//------------------------------------------------------------------------------
// sts_rsp_if
// Result channel: styled runs.
//------------------------------------------------------------------------------
`default_nettype none

interface sts_rsp_if import sts_pkg::*; #(
   parameter int RUN_BITS = 16
) ();

   logic                valid;
   logic                ready;
   logic [RUN_BITS-1:0] run_length;
   logic [STYLE_W-1:0]  run_style;
   logic                last;

   modport source (
      output valid, run_length, run_style, last,
      input  ready
   );

   modport sink (
      input  valid, run_length, run_style, last,
      output ready
   );

endinterface

`default_nettype wire

@@ hw/rtl/sts_csr_if.sv @@
//------------------------------------------------------------------------------
// sts_csr_if
// Configuration write channel for the keyword count register.
//------------------------------------------------------------------------------
`default_nettype none

interface sts_csr_if import sts_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] keyword_count;

   modport source (
      output valid, keyword_count,
      input  ready
   );

   modport sink (
      input  valid, keyword_count,
      output ready
   );

endinterface

`default_nettype wire

@@ hw/rtl/syntax_token_styler_top.sv @@
//------------------------------------------------------------------------------
// syntax_token_styler_top
// Streaming lexer that turns source text into styled (length, style) runs.
//------------------------------------------------------------------------------
// The block takes one item per clock while it is not stalled: either a text
// character or a keyword table load. Each character gives zero, one or two
// runs; a run passes through the item queue and then the output register
// before it is delivered. Characters and loads are taken at one per cycle
// for as long as the result side keeps up; a character that closes a number
// or an identifier and at once produces a run of its own occupies the single
// result port with two runs, so the back end holds the following character
// until the second run has left the pending register. The keyword lookup is
// combinational: every enabled table entry is matched in parallel.
// A two-item queue sits between the classifier and the lexer, and a pending
// register behind the output register holds the second run of an item, so
// either side can stall without losing an item. Loads take effect for all
// characters that follow them in the stream. The keyword count register must
// be written only while no items are in flight.
//------------------------------------------------------------------------------
`default_nettype none

module syntax_token_styler_top import sts_pkg::*; #(
   parameter int KW_ENTRIES   = 32,
   parameter int KW_MAX_CHARS = 8,
   parameter int RUN_BITS     = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sts_req_if.sink    req_chan,
   sts_rsp_if.source  rsp_chan,
   sts_csr_if.sink    csr_chan
);

   // Keyword count register; it is always ready for a write.
   logic [COUNT_W-1:0] keyword_count_ff, keyword_count_in;

   // Decoded items between the front end and the back end.
   logic       op_valid;
   logic       op_pop;
   sts_op_type op;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      keyword_count_in = keyword_count_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         keyword_count_in = csr_chan.keyword_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keyword_count_ff <= '0;
      end else begin
         keyword_count_ff <= keyword_count_in;
      end
   end

   // The front end classifies each character as it is accepted.
   sts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .op_valid (op_valid),
      .op       (op),
      .op_pop   (op_pop)
   );

   // The back end runs the lexer, looks up keywords and delivers the runs.
   sts_back #(
      .KW_ENTRIES   (KW_ENTRIES),
      .KW_MAX_CHARS (KW_MAX_CHARS),
      .RUN_BITS     (RUN_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (op_valid),
      .op            (op),
      .op_pop        (op_pop),
      .keyword_count (keyword_count_ff),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .run_length    (rsp_chan.run_length),
      .run_style     (rsp_chan.run_style),
      .run_last      (rsp_chan.last)
   );

endmodule

`default_nettype wire

@@ hw/rtl/sts_front.sv @@
//------------------------------------------------------------------------------
// sts_front
// Accepts input items, classifies the character and queues decoded items.
//------------------------------------------------------------------------------
`default_nettype none

module sts_front import sts_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   sts_req_if.sink     req,
   output logic        op_valid,
   output sts_op_type  op,
   input  wire logic   op_pop
);

   sts_op_type    q_ff [2];
   sts_op_type    op_in;
   sts_class_type cls;
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push;

   always_comb begin
      cls.quote        = (req.char_code == CH_QUOTE);
      cls.digit        = req.char_code inside {[8'h30:8'h39]};
      cls.alpha        = req.char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]};
      cls.hex_or_x     = cls.digit || (req.char_code == CH_X)
                         || (req.char_code inside {[8'h41:8'h46], [8'h61:8'h66]});
      cls.colon        = (req.char_code == CH_COLON);
      cls.under_dollar = (req.char_code == CH_UNDERSCORE) || (req.char_code == CH_DOLLAR);
   end

   always_comb begin
      op_in.load       = (req.command == CMD_LOAD);
      op_in.line_start = req.line_start;
      op_in.char_code  = req.char_code;
      op_in.cls        = cls;
      op_in.kw_index   = req.kw_index;
      op_in.kw_chars   = req.kw_chars;
      op_in.kw_length  = req.kw_length;
   end

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign op_valid  = (count_ff != 2'd0);
   assign op        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ op_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, op_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/sts_kw_table.sv @@
//------------------------------------------------------------------------------
// sts_kw_table
// Keyword table storage and parallel match against the current identifier.
//------------------------------------------------------------------------------
`default_nettype none

module sts_kw_table import sts_pkg::*; #(
   parameter int KW_ENTRIES   = 32,
   parameter int KW_MAX_CHARS = 8,
   parameter int RUN_BITS     = 16
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [KW_INDEX_W-1:0] wr_index,
   input  wire logic [KW_CHARS_W-1:0] wr_chars,
   input  wire logic [KW_LEN_W-1:0]   wr_length,
   input  wire logic [COUNT_W-1:0]    keyword_count,
   input  wire logic [CHAR_W-1:0]     ident [KW_MAX_CHARS],
   input  wire logic [RUN_BITS-1:0]   id_length,
   input  wire logic                  too_long,
   output logic                       match
);

   localparam int ID_W = KW_MAX_CHARS * CHAR_W;

   logic [KW_CHARS_W-1:0] chars_ff [KW_ENTRIES];
   logic [KW_LEN_W-1:0]   len_ff   [KW_ENTRIES];
   logic [KW_ENTRIES-1:0] hit;

   // The table has no reset; an entry is meaningful once it has been loaded.
   always_ff @(posedge clock) begin
      for (int e = 0; e < KW_ENTRIES; e++) begin
         if (wr_en && (32'(wr_index) == e)) begin
            chars_ff[e] <= wr_chars;
            len_ff[e]   <= wr_length;
         end
      end
   end

   // Characters beyond those held in a table entry compare as zero.
   always_comb begin
      logic [ID_W-1:0]   wide;
      logic [CHAR_W-1:0] kc;
      for (int e = 0; e < KW_ENTRIES; e++) begin
         wide   = ID_W'(chars_ff[e]);
         hit[e] = (32'(keyword_count) > e) && (RUN_BITS'(len_ff[e]) == id_length);
         for (int i = 0; i < KW_MAX_CHARS; i++) begin
            kc = wide[CHAR_W*i +: CHAR_W];
            if ((id_length > RUN_BITS'(i)) && (kc != ident[i])) begin
               hit[e] = 1'b0;
            end
         end
      end
      match = !too_long && (id_length != '0)
              && (id_length <= RUN_BITS'(KW_MAX_CHARS)) && (|hit);
   end

endmodule

`default_nettype wire

@@ hw/rtl/sts_back.sv @@
//------------------------------------------------------------------------------
// sts_back
// Lexer state machine, keyword lookup and the result output stage.
//------------------------------------------------------------------------------
`default_nettype none

module sts_back import sts_pkg::*; #(
   parameter int KW_ENTRIES   = 32,
   parameter int KW_MAX_CHARS = 8,
   parameter int RUN_BITS     = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               op_valid,
   input  wire sts_op_type         op,
   output logic                    op_pop,
   input  wire logic [COUNT_W-1:0] keyword_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [RUN_BITS-1:0]     run_length,
   output logic [STYLE_W-1:0]      run_style,
   output logic                    run_last
);

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_IDENT  = 2'd1;
   localparam logic [1:0] MODE_NUMBER = 2'd2;
   localparam logic [1:0] MODE_STRING = 2'd3;

   localparam logic [RUN_BITS-1:0] LEN_ONE = RUN_BITS'(1);

   logic [1:0]          mode_ff, mode_in, mode_cur;
   logic [RUN_BITS-1:0] len_ff, len_in, len_cur;
   logic [CHAR_W-1:0]   ident_ff [KW_MAX_CHARS];
   logic [CHAR_W-1:0]   ident_in [KW_MAX_CHARS];
   logic [CHAR_W-1:0]   ident_cur [KW_MAX_CHARS];
   logic                too_long_ff, too_long_in, too_long_cur;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RUN_BITS-1:0] out_len_ff, out_len_in;
   logic [STYLE_W-1:0]  out_style_ff, out_style_in;
   logic                out_last_ff, out_last_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [RUN_BITS-1:0] pend_len_ff, pend_len_in;
   logic [STYLE_W-1:0]  pend_style_ff, pend_style_in;

   logic [1:0]          run_count;
   logic [RUN_BITS-1:0] run0_len, run1_len;
   logic [STYLE_W-1:0]  run0_style, run1_style;
   logic                again;
   logic                kw_match;
   logic                out_free;
   logic                text_pop;
   logic                cont;

   function automatic logic [RUN_BITS-1:0] sat_inc(input logic [RUN_BITS-1:0] v);
      return (&v) ? v : v + LEN_ONE;
   endfunction

   sts_kw_table #(
      .KW_ENTRIES   (KW_ENTRIES),
      .KW_MAX_CHARS (KW_MAX_CHARS),
      .RUN_BITS     (RUN_BITS)
   ) u_kw_table (
      .clock         (clock),
      .wr_en         (op_pop && op.load),
      .wr_index      (op.kw_index),
      .wr_chars      (op.kw_chars),
      .wr_length     (op.kw_length),
      .keyword_count (keyword_count),
      .ident         (ident_cur),
      .id_length     (len_cur),
      .too_long      (too_long_cur),
      .match         (kw_match)
   );

   // A load never waits for the result side; a character waits for a free output slot.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign op_pop   = op_valid && (op.load || (!pend_valid_ff && out_free));
   assign text_pop = op_pop && !op.load;

   // Start of line clears the token before the character is looked at.
   always_comb begin
      if (op.line_start) begin
         mode_cur     = MODE_IDLE;
         len_cur      = '0;
         too_long_cur = 1'b0;
         for (int i = 0; i < KW_MAX_CHARS; i++) ident_cur[i] = '0;
      end else begin
         mode_cur     = mode_ff;
         len_cur      = len_ff;
         too_long_cur = too_long_ff;
         ident_cur    = ident_ff;
      end
   end

   always_comb begin
      mode_in     = mode_cur;
      len_in      = len_cur;
      ident_in    = ident_cur;
      too_long_in = too_long_cur;
      run_count   = 2'd0;
      run0_len    = '0;
      run0_style  = ST_DEFAULT;
      run1_len    = '0;
      run1_style  = ST_DEFAULT;
      again       = 1'b0;
      cont        = op.cls.alpha || op.cls.digit || (op.cls.under_dollar && (len_cur == '0));

      case (mode_cur)
         MODE_STRING: begin
            len_in = sat_inc(len_cur);
            if (op.cls.quote) begin
               run_count  = 2'd1;
               run0_len   = len_in;
               run0_style = ST_STRING;
               mode_in    = MODE_IDLE;
               len_in     = '0;
            end
         end
         MODE_NUMBER: begin
            if (op.cls.hex_or_x) begin
               len_in = sat_inc(len_cur);
            end else begin
               run_count  = 2'd1;
               run0_len   = len_cur;
               run0_style = ST_NUMBER;
               again      = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (cont) begin
               for (int i = 0; i < KW_MAX_CHARS; i++) begin
                  if (len_cur == RUN_BITS'(i)) ident_in[i] = op.char_code;
               end
               if (len_cur >= RUN_BITS'(KW_MAX_CHARS)) too_long_in = 1'b1;
               len_in = sat_inc(len_cur);
            end else if (!kw_match && op.cls.colon) begin
               // The colon belongs to the label run.
               run_count   = 2'd1;
               run0_len    = sat_inc(len_cur);
               run0_style  = ST_LABEL;
               mode_in     = MODE_IDLE;
               len_in      = '0;
               too_long_in = 1'b0;
               for (int i = 0; i < KW_MAX_CHARS; i++) ident_in[i] = '0;
            end else begin
               run_count  = 2'd1;
               run0_len   = len_cur;
               run0_style = kw_match ? ST_KEYWORD : ST_IDENT;
               again      = 1'b1;
            end
         end
         default: begin
            again = 1'b1;
         end
      endcase

      // The character is looked at again from outside any token.
      if (again) begin
         mode_in     = MODE_IDLE;
         len_in      = '0;
         too_long_in = 1'b0;
         for (int i = 0; i < KW_MAX_CHARS; i++) ident_in[i] = '0;
         if (op.cls.quote || !(op.cls.digit || op.cls.alpha || op.cls.under_dollar)) begin
            if (run_count == 2'd0) begin
               run0_len   = LEN_ONE;
               run0_style = op.cls.quote ? ST_STRING : ST_DEFAULT;
            end else begin
               run1_len   = LEN_ONE;
               run1_style = op.cls.quote ? ST_STRING : ST_DEFAULT;
            end
            run_count = run_count + 2'd1;
            if (op.cls.quote) mode_in = MODE_STRING;
         end else if (op.cls.digit) begin
            mode_in = MODE_NUMBER;
            len_in  = LEN_ONE;
         end else begin
            mode_in     = MODE_IDENT;
            ident_in[0] = op.char_code;
            len_in      = LEN_ONE;
         end
      end
   end

   // Output stage: a second run waits in the pending register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_len_in    = out_len_ff;
      out_style_in  = out_style_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_len_in   = pend_len_ff;
      pend_style_in = pend_style_ff;
      if (out_free) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            out_len_in    = pend_len_ff;
            out_style_in  = pend_style_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else if (text_pop && (run_count != 2'd0)) begin
            rsp_valid_in = 1'b1;
            out_len_in   = run0_len;
            out_style_in = run0_style;
            out_last_in  = (run_count == 2'd1);
            if (run_count == 2'd2) begin
               pend_valid_in = 1'b1;
               pend_len_in   = run1_len;
               pend_style_in = run1_style;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         len_ff        <= '0;
         too_long_ff   <= 1'b0;
         for (int i = 0; i < KW_MAX_CHARS; i++) ident_ff[i] <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (text_pop) begin
            mode_ff     <= mode_in;
            len_ff      <= len_in;
            too_long_ff <= too_long_in;
            ident_ff    <= ident_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_len_ff    <= out_len_in;
      out_style_ff  <= out_style_in;
      out_last_ff   <= out_last_in;
      pend_len_ff   <= pend_len_in;
      pend_style_ff <= pend_style_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign run_length = out_len_ff;
   assign run_style  = out_style_ff;
   assign run_last   = out_last_ff;

endmodule

`default_nettype wire

@@ bench/syntax_token_styler_top_test.sv @@
//------------------------------------------------------------------------------
// syntax_token_styler_top_test
// Self-checking bench for the streaming syntax token styler.
//------------------------------------------------------------------------------
// Text characters and keyword table loads go in on the request channel. Every
// accepted item is run through a behavioural lexer kept in this bench, and the
// styled runs that it predicts are queued. Each run that leaves the block is
// compared field by field with the oldest queued run. The directed tests cover
// each token class, keyword and label rules and dropped runs at a line start.
// Random text then follows under several keyword count settings, with random
// idling on both channels in all but one of them.
//------------------------------------------------------------------------------

module syntax_token_styler_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sts_pkg::*;

   localparam int KW_ENTRIES    = 32;
   localparam int KW_MAX_CHARS  = 8;
   localparam int RUN_BITS      = 16;
   localparam int unsigned RUN_MAX = (1 << RUN_BITS) - 1;

   // Margin that settle() waits after the last predicted run, for loads still in flight.
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 1_000_000;

   // Lexer modes of the behavioural model.
   typedef enum logic [1:0] {
      LEX_IDLE,
      LEX_IDENT,
      LEX_NUMBER,
      LEX_STRING
   } lex_mode_type;

   // One request item, laid out as it is driven onto the channel.
   typedef struct packed {
      logic                  command;
      logic [CHAR_W-1:0]     char_code;
      logic                  line_start;
      logic [KW_INDEX_W-1:0] kw_index;
      logic [KW_CHARS_W-1:0] kw_chars;
      logic [KW_LEN_W-1:0]   kw_length;
   } styler_item_type;

   // One styled run as it leaves the block.
   typedef struct packed {
      logic [RUN_BITS-1:0] run_length;
      logic [STYLE_W-1:0]  run_style;
      logic                last;
   } styled_run_type;

   logic clock;
   logic reset;

   sts_req_if                          req_chan ();
   sts_rsp_if #(.RUN_BITS(RUN_BITS))   rsp_chan ();
   sts_csr_if                          csr_chan ();

   syntax_token_styler_top #(
      .KW_ENTRIES   (KW_ENTRIES),
      .KW_MAX_CHARS (KW_MAX_CHARS),
      .RUN_BITS     (RUN_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Behavioural lexer state. It shadows the block's own state exactly, so the
   // runs it predicts are the runs that the block must produce.
   lex_mode_type          lex_mode;
   int unsigned           tok_len;
   logic [CHAR_W-1:0]     id_chars [KW_MAX_CHARS];
   bit                    id_too_long;
   logic [KW_CHARS_W-1:0] entry_chars [KW_ENTRIES];
   logic [KW_LEN_W-1:0]   entry_len [KW_ENTRIES];
   int unsigned           kw_enabled;

   // Runs predicted but not yet seen on the result channel, oldest first.
   styled_run_type pending_runs[$];
   int             runs_this_item;

   int  req_idle_pct = 10;
   int  rsp_idle_pct = 10;
   bit  line_break_due;

   int  error_count;
   int  items_sent;
   int  loads_sent;
   int  runs_checked;
   int  csr_writes;
   int  cycle_count;

   styled_run_type oldest_run;

   // Free-running clock with a 12 ns period.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The run is bounded in cycles so that a hung handshake cannot go unseen.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The result side stalls about ten percent of the time, unless a test has
   // switched idling off.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Every accepted run is matched against the oldest predicted run. Values are
   // read in the active region of the edge, so they are the ones from before it.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_runs.size() == 0) begin
            $error("unexpected run: run_length %0d, run_style %0d, last %0d",
                   rsp_chan.run_length, rsp_chan.run_style, rsp_chan.last);
            error_count++;
         end else begin
            oldest_run = pending_runs.pop_front();
            runs_checked++;
            if (rsp_chan.run_length !== oldest_run.run_length) begin
               $error("run_length mismatch: expected %0d, actual %0d",
                      oldest_run.run_length, rsp_chan.run_length);
               error_count++;
            end
            if (rsp_chan.run_style !== oldest_run.run_style) begin
               $error("run_style mismatch: expected %0d, actual %0d",
                      oldest_run.run_style, rsp_chan.run_style);
               error_count++;
            end
            if (rsp_chan.last !== oldest_run.last) begin
               $error("last mismatch: expected %0d, actual %0d",
                      oldest_run.last, rsp_chan.last);
               error_count++;
            end
         end
      end
   end

   //---------------------------------------------------------------------------
   // Behavioural lexer
   //---------------------------------------------------------------------------

   function automatic int unsigned len_plus_one(input int unsigned v);
      return (v >= RUN_MAX) ? RUN_MAX : v + 1;
   endfunction

   function automatic bit char_digit(input logic [CHAR_W-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit char_alpha(input logic [CHAR_W-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit char_hex_or_x(input logic [CHAR_W-1:0] c);
      return char_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")
             || c == CH_X;
   endfunction

   function automatic void drop_token();
      lex_mode    = LEX_IDLE;
      tok_len     = 0;
      id_too_long = 1'b0;
      for (int i = 0; i < KW_MAX_CHARS; i++) id_chars[i] = '0;
   endfunction

   // Only the first kw_enabled entries take part, and a count above the table
   // size behaves as the full table.
   function automatic bit ident_is_keyword();
      int unsigned n;
      bit          same;
      n = (kw_enabled > KW_ENTRIES) ? KW_ENTRIES : kw_enabled;
      if (id_too_long || tok_len == 0 || tok_len > KW_MAX_CHARS) return 1'b0;
      for (int e = 0; e < n; e++) begin
         if (entry_len[e] == tok_len) begin
            same = 1'b1;
            for (int i = 0; i < tok_len; i++) begin
               if (entry_chars[e][8*i +: 8] != id_chars[i]) same = 1'b0;
            end
            if (same) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void add_run(input int unsigned len,
                                   input logic [STYLE_W-1:0] style);
      styled_run_type r;
      r.run_length = len[RUN_BITS-1:0];
      r.run_style  = style;
      r.last       = 1'b0;
      pending_runs.push_back(r);
      runs_this_item++;
   endfunction

   // Advances the lexer by one accepted item and queues the runs it causes.
   function automatic void predict_runs(input styler_item_type it);
      logic [CHAR_W-1:0] c;
      bit                again;
      bit                kw;
      styled_run_type    tail_run;
      if (it.command == CMD_LOAD) begin
         entry_chars[it.kw_index] = it.kw_chars;
         entry_len[it.kw_index]   = it.kw_length;
         return;
      end
      c = it.char_code;
      runs_this_item = 0;
      if (it.line_start) drop_token();
      do begin
         again = 1'b0;
         case (lex_mode)
            LEX_IDLE: begin
               if (c == CH_QUOTE) begin
                  add_run(1, ST_STRING);
                  lex_mode = LEX_STRING;
               end else if (char_digit(c)) begin
                  lex_mode = LEX_NUMBER;
                  again    = 1'b1;
               end else if (char_alpha(c) || c == CH_UNDERSCORE || c == CH_DOLLAR) begin
                  lex_mode = LEX_IDENT;
                  again    = 1'b1;
               end else begin
                  add_run(1, ST_DEFAULT);
               end
            end
            LEX_STRING: begin
               tok_len = len_plus_one(tok_len);
               if (c == CH_QUOTE) begin
                  add_run(tok_len, ST_STRING);
                  drop_token();
               end
            end
            LEX_NUMBER: begin
               if (char_hex_or_x(c)) begin
                  tok_len = len_plus_one(tok_len);
               end else begin
                  add_run(tok_len, ST_NUMBER);
                  drop_token();
                  again = 1'b1;
               end
            end
            default: begin
               // '_' and '$' may only open an identifier.
               if (char_alpha(c) || char_digit(c) ||
                   ((c == CH_UNDERSCORE || c == CH_DOLLAR) && tok_len == 0)) begin
                  if (tok_len < KW_MAX_CHARS) id_chars[tok_len] = c;
                  else id_too_long = 1'b1;
                  tok_len = len_plus_one(tok_len);
               end else begin
                  kw = ident_is_keyword();
                  if (!kw && c == CH_COLON) begin
                     add_run(len_plus_one(tok_len), ST_LABEL);
                     drop_token();
                  end else begin
                     add_run(tok_len, kw ? ST_KEYWORD : ST_IDENT);
                     drop_token();
                     again = 1'b1;
                  end
               end
            end
         endcase
      end while (again);
      if (runs_this_item > 0) begin
         tail_run      = pending_runs.pop_back();
         tail_run.last = 1'b1;
         pending_runs.push_back(tail_run);
      end
   endfunction

   //---------------------------------------------------------------------------
   // Stimulus helpers
   //---------------------------------------------------------------------------

   // Presents one item and holds it until the block takes it. Valid is only
   // lowered here when an idle gap is taken, so back-to-back items keep it high.
   task automatic send_item(input styler_item_type it);
      if ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_chan.valid      <= 1'b1;
      req_chan.command    <= it.command;
      req_chan.char_code  <= it.char_code;
      req_chan.line_start <= it.line_start;
      req_chan.kw_index   <= it.kw_index;
      req_chan.kw_chars   <= it.kw_chars;
      req_chan.kw_length  <= it.kw_length;
      do @(posedge clock); while (!req_chan.ready);
      predict_runs(it);
      items_sent++;
      if (it.command == CMD_LOAD) loads_sent++;
   endtask

   // A text character; the load fields carry random junk that must be ignored.
   task automatic send_char(input logic [CHAR_W-1:0] c, input bit ls);
      styler_item_type it;
      it.command    = CMD_TEXT;
      it.char_code  = c;
      it.line_start = ls;
      it.kw_index   = KW_INDEX_W'($urandom);
      it.kw_chars   = {$urandom, $urandom};
      it.kw_length  = KW_LEN_W'($urandom);
      send_item(it);
   endtask

   // A table load; the text fields carry random junk that must be ignored.
   task automatic send_load(input logic [KW_INDEX_W-1:0] idx,
                            input logic [KW_CHARS_W-1:0] chars,
                            input logic [KW_LEN_W-1:0] len);
      styler_item_type it;
      it.command    = CMD_LOAD;
      it.char_code  = CHAR_W'($urandom);
      it.line_start = 1'($urandom);
      it.kw_index   = idx;
      it.kw_chars   = chars;
      it.kw_length  = len;
      send_item(it);
   endtask

   // Sends a whole line, with the line start flag on its first character.
   task automatic send_line(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
   endtask

   // Random text raises a line start where a break is due, and now and then
   // at an arbitrary point, which cuts off whatever token is open.
   task automatic send_text_char(input logic [CHAR_W-1:0] c);
      bit ls;
      ls = line_break_due || ($urandom_range(49) == 0);
      line_break_due = 1'b0;
      send_char(c, ls);
   endtask

   // Waits until every predicted run has been seen and the block has had time
   // to finish any load still in flight, since loads give no result to wait on.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_runs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The keyword count may only change while the block is idle.
   task automatic write_keyword_count(input logic [COUNT_W-1:0] value);
      settle();
      csr_chan.valid         <= 1'b1;
      csr_chan.keyword_count <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      kw_enabled = 32'(value);
      csr_writes++;
   endtask

   function automatic logic [KW_CHARS_W-1:0] pack_word(input string w);
      logic [KW_CHARS_W-1:0] p;
      p = '0;
      for (int i = 0; i < w.len() && i < KW_MAX_CHARS; i++) p[8*i +: 8] = w[i];
      return p;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_ident_head();
      int unsigned k;
      k = $urandom_range(53);
      if (k < 26) return 8'(k) + 8'h61;
      if (k < 52) return 8'(k - 26) + 8'h41;
      return (k == 52) ? CH_UNDERSCORE : CH_DOLLAR;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_ident_tail();
      int unsigned k;
      k = $urandom_range(61);
      if (k < 26) return 8'(k) + 8'h61;
      if (k < 52) return 8'(k - 26) + 8'h41;
      return 8'(k - 52) + 8'h30;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_hex_or_x();
      string digits;
      digits = "0123456789abcdefABCDEFx";
      return digits[$urandom_range(digits.len() - 1)];
   endfunction

   function automatic logic [CHAR_W-1:0] pick_separator();
      string marks;
      marks = " ;,(){}+-*/=<>\t.";
      return marks[$urandom_range(marks.len() - 1)];
   endfunction

   // Half of the random loads are well-formed identifiers that later text can
   // hit; the rest are raw bit patterns with any length, including ones that
   // can never match.
   task automatic send_random_load();
      logic [KW_CHARS_W-1:0] w;
      int unsigned           n;
      if ($urandom_range(1) == 0) begin
         n = $urandom_range(KW_MAX_CHARS, 1);
         w = '0;
         w[7:0] = pick_ident_head();
         for (int i = 1; i < n; i++) w[8*i +: 8] = pick_ident_tail();
         send_load(KW_INDEX_W'($urandom_range(KW_ENTRIES - 1)), w, KW_LEN_W'(n));
      end else begin
         send_load(KW_INDEX_W'($urandom_range(KW_ENTRIES - 1)), {$urandom, $urandom},
                   KW_LEN_W'($urandom_range(15)));
      end
   endtask

   // One random token. Most of them are well-formed, so that the lexer spends
   // its time inside tokens; a share is noise, loads and cut lines.
   task automatic send_random_token();
      int unsigned pick;
      int unsigned n;
      int unsigned e;
      pick = $urandom_range(99);
      if (pick < 15) begin
         // A word taken from the table, whether or not it is enabled.
         e = $urandom_range(KW_ENTRIES - 1);
         n = (entry_len[e] > KW_MAX_CHARS) ? KW_MAX_CHARS : entry_len[e];
         for (int i = 0; i < n; i++) send_text_char(entry_chars[e][8*i +: 8]);
         send_text_char(($urandom_range(3) == 0) ? CH_COLON : pick_separator());
      end else if (pick < 35) begin
         send_text_char(pick_ident_head());
         n = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(6);
         repeat (n) send_text_char(pick_ident_tail());
      end else if (pick < 50) begin
         send_text_char(8'($urandom_range(9)) + 8'h30);
         repeat ($urandom_range(5)) send_text_char(pick_hex_or_x());
      end else if (pick < 60) begin
         send_text_char(CH_QUOTE);
         repeat ($urandom_range(6)) send_text_char(8'($urandom_range(126, 35)));
         if ($urandom_range(7) == 0) line_break_due = 1'b1;
         else send_text_char(CH_QUOTE);
      end else if (pick < 70) begin
         send_text_char(pick_ident_head());
         repeat ($urandom_range(5)) send_text_char(pick_ident_tail());
         send_text_char(CH_COLON);
      end else if (pick < 85) begin
         send_text_char(pick_separator());
      end else if (pick < 90) begin
         line_break_due = 1'b1;
      end else if (pick < 95) begin
         send_text_char(CHAR_W'($urandom_range(255)));
      end else begin
         send_random_load();
      end
   endtask

   //---------------------------------------------------------------------------
   // Tests
   //---------------------------------------------------------------------------

   // Loads the named entries and as many random loads as there are further
   // entries, at random indices, and then enables the whole table.
   task automatic test_table_load();
      send_load(0, pack_word("if"), 2);
      send_load(1, pack_word("else"), 4);
      send_load(2, pack_word("while"), 5);
      send_load(3, pack_word("for"), 3);
      send_load(4, pack_word("return"), 6);
      send_load(5, pack_word("begin"), 5);
      send_load(6, pack_word("unsigned"), 8);
      send_load(7, pack_word("$display"), 8);
      // An empty entry, and two whose lengths exceed the widest keyword.
      send_load(8, {$urandom, $urandom}, 0);
      send_load(9, pack_word("abcdefgh"), 12);
      send_load(10, '1, 15);
      for (int e = 11; e < KW_ENTRIES; e++) send_random_load();
      // The random loads above may have hit the named entries again.
      send_load(0, pack_word("if"), 2);
      send_load(6, pack_word("unsigned"), 8);
      write_keyword_count(COUNT_W'(KW_ENTRIES));
   endtask

   // A short walk through each token class and each rule of the lexer.
   task automatic test_directed_tokens();
      send_line("if:");         // keyword, then the colon on its own
      send_line("ab:");         // label that takes in the colon
      send_line("0xFz+");       // number ended by a letter; '+' gives two runs
      send_line("\"s");         // unterminated string, dropped at the next line
      send_line("_a$");         // '$' cannot continue an identifier
      send_char(8'hFF, 1'b1);   // codes above 127 are plain characters
      send_char(8'h80, 1'b0);
      send_char(8'h00, 1'b0);
      send_line("abcdefgh;");   // matches nothing: entry nine is too long
      send_line("unsigned ");   // widest keyword
   endtask

   task automatic test_random_text(input logic [COUNT_W-1:0] count,
                                   input int n, input bit no_idle);
      int target;
      write_keyword_count(count);
      req_idle_pct = no_idle ? 0 : 10;
      rsp_idle_pct = no_idle ? 0 : 10;
      line_break_due = 1'b1;
      target = items_sent + n;
      while (items_sent < target) send_random_token();
      req_idle_pct = 10;
      rsp_idle_pct = 10;
   endtask

   //---------------------------------------------------------------------------
   // Sequence of tests
   //---------------------------------------------------------------------------

   initial begin
      // Every input of the block but the result ready holds a known value from the first instant.
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.command       <= CMD_TEXT;
      req_chan.char_code     <= '0;
      req_chan.line_start    <= 1'b0;
      req_chan.kw_index      <= '0;
      req_chan.kw_chars      <= '0;
      req_chan.kw_length     <= '0;
      csr_chan.valid         <= 1'b0;
      csr_chan.keyword_count <= '0;
      kw_enabled             = 0;
      line_break_due         = 1'b0;
      drop_token();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_load();
      test_directed_tokens();

      // The extremes of the keyword count come first: nothing enabled, the
      // whole table, and a value beyond the table, which acts as the whole
      // table. The latter runs with no idling on either side.
      test_random_text(0, 250, 1'b0);
      test_random_text(COUNT_W'(KW_ENTRIES), 250, 1'b0);
      test_random_text('1, 250, 1'b1);
      test_random_text(COUNT_W'($urandom_range(KW_ENTRIES - 1, 1)), 300, 1'b0);
      test_random_text(1, 250, 1'b0);

      settle();
      $display("Run covered %0d items, %0d of them table loads, and %0d styled runs,",
               items_sent, loads_sent, runs_checked);
      $display("over %0d keyword count settings; %0d mismatches were found.",
               csr_writes, error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ syntax_token_styler_top.f @@
hw/rtl/sts_pkg.sv
hw/rtl/sts_req_if.sv
hw/rtl/sts_rsp_if.sv
hw/rtl/sts_csr_if.sv
hw/rtl/sts_front.sv
hw/rtl/sts_kw_table.sv
hw/rtl/sts_back.sv
hw/rtl/syntax_token_styler_top.sv
bench/syntax_token_styler_top_test.sv
